>>> design/trial_division_primality_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trial division primality tester
// Clocked property checks with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIMALITY_DEFINES_SVH
`define TRIAL_DIVISION_PRIMALITY_DEFINES_SVH

`ifndef SYNTHESIS

`define TDP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define TDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TDP_ASSERT(lbl, clk, rst, prop, msg)

`define TDP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> design/tdp_pkg.sv
// ----------------------------------------------------------------------------
// Trial division primality package
// Sequencer states, divider status and the fixed divisor constants.
// ----------------------------------------------------------------------------
package tdp_pkg;

   // first trial divisor of the 6k +/- 1 walk and its step
   localparam int FACTOR_THREE  = 3;
   localparam int FIRST_DIVISOR = 5;
   localparam int PAIR_OFFSET   = 2;
   localparam int DIVISOR_STEP  = 6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_THREE,
      ST_DIV_LOW,
      ST_DIV_HIGH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> design/tdp_req_if.sv
// ----------------------------------------------------------------------------
// Candidate channel
// Valid/ready channel that carries one candidate value per beat.
// ----------------------------------------------------------------------------
interface tdp_req_if #(
   parameter int VALUE_BITS = 48
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

>>> design/tdp_rsp_if.sv
// ----------------------------------------------------------------------------
// Verdict channel
// Valid/ready channel that carries one prime flag per beat.
// ----------------------------------------------------------------------------
interface tdp_rsp_if;
   logic valid;
   logic ready;
   logic prime_flag;

   modport source (output valid, output prime_flag, input ready);
   modport sink   (input valid, input prime_flag, output ready);
endinterface

>>> design/tdp_divider.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring radix-2 divider, one quotient bit per cycle, quotient and
// remainder held after the done pulse until the next start.
// ----------------------------------------------------------------------------
`include "trial_division_primality_defines.svh"

module tdp_divider #(
   parameter int VALUE_BITS = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_BITS-1:0]  dividend,
   input  logic [VALUE_BITS-1:0]  divisor,
   output tdp_pkg::div_status_type status,
   output logic [VALUE_BITS-1:0]  quotient,
   output logic [VALUE_BITS-1:0]  remainder
);
   import tdp_pkg::*;

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] dq_ff, dq_in;
   logic [VALUE_BITS-1:0] divisor_ff;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [VALUE_BITS:0]   shifted;
   logic [VALUE_BITS:0]   diff;
   logic                  fits;

   // bring down the next dividend bit and try the subtract
   assign shifted = {rem_ff, dq_ff[VALUE_BITS-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         dq_in    = dividend;
         count_in = CNT_BITS'(VALUE_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
         dq_in    = {dq_ff[VALUE_BITS-2:0], fits};
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      if (start) begin
         divisor_ff <= divisor;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = dq_ff;
   assign remainder   = rem_ff;

   `TDP_ASSERT(a_rem_below_divisor, clock, reset, done_ff |-> (rem_ff < divisor_ff), "remainder not below divisor")
   `TDP_ASSERT(a_start_when_free, clock, reset, start |-> !busy_ff, "divider started while busy")
   `TDP_ASSERT(a_done_pulse, clock, reset, done_ff |=> !done_ff, "done held longer than one cycle")
   `TDP_ASSERT(a_busy_count, clock, reset, busy_ff |-> (count_ff != '0), "busy with empty bit count")

endmodule

>>> design/trial_division_primality.sv
// ----------------------------------------------------------------------------
// Trial division primality tester
// Flags each candidate as prime or not by trial division over 6k +/- 1.
// ----------------------------------------------------------------------------
// One candidate is taken per request beat and one prime flag leaves per
// response beat. Candidates 0 through 3 and even values skip the divider.
// Anything else runs through a bit-serial divider, one trial remainder at
// a time: one division by 3, then divisions by d and d + 2 for
// d = 5, 11, 17, ... while d <= candidate / d. A finished flag sits in an
// output register, so a new candidate is taken as soon as the flag is
// parked there. No warm-up after reset.
`include "trial_division_primality_defines.svh"

module trial_division_primality #(
   parameter int VALUE_BITS = 48
) (
   input  logic      clock,
   input  logic      reset,
   tdp_req_if.sink   req_chan,
   tdp_rsp_if.source rsp_chan
);
   import tdp_pkg::*;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] divisor_ff, divisor_in;
   logic                  flag_ff, flag_in;
   logic                  rsp_valid_ff;
   logic                  rsp_flag_ff;

   logic                  req_fire;
   logic                  out_free;
   logic                  fast_path;
   logic                  small_prime;
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [VALUE_BITS-1:0] div_divisor;
   logic                  load_divisor;
   logic                  emit;
   div_status_type        div_status;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [VALUE_BITS-1:0] div_remainder;
   logic                  rem_zero;
   logic                  bound_hit;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // 0..3 and even values need no division
   assign small_prime = (req_chan.candidate == VALUE_BITS'(PAIR_OFFSET))
                     || (req_chan.candidate == VALUE_BITS'(FACTOR_THREE));
   assign fast_path   = (req_chan.candidate <= VALUE_BITS'(FACTOR_THREE))
                     || !req_chan.candidate[0];

   assign rem_zero  = (div_remainder == '0);
   assign bound_hit = divisor_ff > div_quotient;

   assign div_dividend = (state_ff == ST_IDLE) ? req_chan.candidate : value_ff;

   tdp_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = fast_path ? ST_EMIT : ST_DIV_THREE;
            end
         end
         ST_DIV_THREE: begin
            if (div_status.done) begin
               state_in = rem_zero ? ST_EMIT : ST_DIV_LOW;
            end
         end
         ST_DIV_LOW: begin
            if (div_status.done) begin
               state_in = (bound_hit || rem_zero) ? ST_EMIT : ST_DIV_HIGH;
            end
         end
         ST_DIV_HIGH: begin
            if (div_status.done) begin
               state_in = rem_zero ? ST_EMIT : ST_DIV_LOW;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      div_start    = 1'b0;
      div_divisor  = VALUE_BITS'(FACTOR_THREE);
      load_divisor = 1'b0;
      divisor_in   = divisor_ff;
      flag_in      = flag_ff;
      emit         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               flag_in   = small_prime;
               div_start = !fast_path;
            end
         end
         ST_DIV_THREE: begin
            if (div_status.done) begin
               if (rem_zero) begin
                  flag_in = 1'b0;
               end else begin
                  div_start    = 1'b1;
                  div_divisor  = VALUE_BITS'(FIRST_DIVISOR);
                  load_divisor = 1'b1;
                  divisor_in   = VALUE_BITS'(FIRST_DIVISOR);
               end
            end
         end
         ST_DIV_LOW: begin
            if (div_status.done) begin
               if (bound_hit) begin
                  flag_in = 1'b1;
               end else if (rem_zero) begin
                  flag_in = 1'b0;
               end else begin
                  div_start   = 1'b1;
                  div_divisor = divisor_ff + VALUE_BITS'(PAIR_OFFSET);
               end
            end
         end
         ST_DIV_HIGH: begin
            if (div_status.done) begin
               if (rem_zero) begin
                  flag_in = 1'b0;
               end else begin
                  div_start    = 1'b1;
                  div_divisor  = divisor_ff + VALUE_BITS'(DIVISOR_STEP);
                  load_divisor = 1'b1;
                  divisor_in   = divisor_ff + VALUE_BITS'(DIVISOR_STEP);
               end
            end
         end
         ST_EMIT: begin
            emit = out_free;
         end
         default: emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      flag_ff <= flag_in;
      if (req_fire) begin
         value_ff <= req_chan.candidate;
      end
      if (load_divisor) begin
         divisor_ff <= divisor_in;
      end
      if (emit) begin
         rsp_flag_ff <= flag_ff;
      end
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.prime_flag = rsp_flag_ff;

   `TDP_ASSERT(a_div_running, clock, reset, ((state_ff == ST_DIV_THREE) || (state_ff == ST_DIV_LOW) || (state_ff == ST_DIV_HIGH)) |-> (div_status.busy || div_status.done), "waiting on an idle divider")
   `TDP_ASSERT(a_divisor_odd, clock, reset, (state_ff == ST_DIV_LOW) |-> divisor_ff[0], "even trial divisor")
   `TDP_ASSERT(a_prime_odd, clock, reset, ((state_ff == ST_EMIT) && flag_ff) |-> (value_ff[0] || (value_ff == VALUE_BITS'(PAIR_OFFSET))), "even value flagged prime")
   `TDP_ASSERT(a_emit_slot, clock, reset, emit |=> rsp_valid_ff, "verdict lost on the way out")

endmodule
